// ----- rtl/core/gdf_pkg.sv -----
// ----------------------------------------------------------------------------
// gdf_pkg
// Shared widths, character codes and status codes of the grouped decimal
// formatter.
// ----------------------------------------------------------------------------
package gdf_pkg;

   localparam int VALUE_BITS = 64;
   localparam int CAP_BITS   = 8;
   localparam int CHAR_BITS  = 8;
   localparam int LEN_BITS   = 5;

   typedef logic [CHAR_BITS-1:0] char_type;
   typedef logic [CAP_BITS-1:0]  cap_type;
   typedef logic [LEN_BITS-1:0]  len_type;

   localparam char_type ASCII_ZERO       = 8'h30;
   localparam char_type GROUP_CHAR_RESET = 8'h2C;
   localparam char_type CHAR_NONE        = 8'h00;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_OVERFLOW = 1'b1;

endpackage

// ----- rtl/core/grouped_decimal_formatter_unit.sv -----
// ----------------------------------------------------------------------------
// grouped_decimal_formatter_unit
// Formats an unsigned number as decimal ASCII with a separator between
// three-digit groups, one character per result beat.
//
//   channel | ports               | handshake
//   --------+---------------------+------------------------------------
//   request | req_value, req_cap. | start high while busy low
//   result  | rsp_*               | rsp_valid strobe, one cycle, no stall
//   csr     | csr_we, csr_wdata   | written on a non-reset edge with csr_we high
//
// One item goes through bit-serial binary to BCD conversion
// (shift-and-add-3), stripping of leading zeros (at most NDIG-1), a
// capacity check, then one character per beat (at most 26 for a
// 64-bit value).
// busy stays high from acceptance until the last beat is issued; that beat
// shows on the ports in the same cycle as busy falls.
// Reset is synchronous and restores the group character to ','.
// ----------------------------------------------------------------------------
module grouped_decimal_formatter_unit
   import gdf_pkg::*;
#(
   parameter int VALUE_WIDTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [VALUE_BITS-1:0] req_value,
   input  cap_type               req_capacity,
   output logic                  rsp_valid,
   output char_type              rsp_char_out,
   output logic                  rsp_last,
   output logic                  rsp_status,
   output len_type               rsp_length,
   input  logic                  csr_we,
   input  char_type              csr_wdata
);

   // decimal digits of 2**VALUE_WIDTH - 1
   localparam int NDIG        = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int BCD_BITS    = NDIG * 4;
   localparam int DIG_BITS    = $clog2(NDIG + 1);
   localparam int CNT_BITS    = $clog2(VALUE_WIDTH);
   localparam int PRINTED_MAX = NDIG + (NDIG - 1) / 3;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CONV  = 3'd1;
   localparam logic [2:0] ST_SKIP  = 3'd2;
   localparam logic [2:0] ST_CHECK = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_BITS-1:0]    bcd_ff, bcd_in, bcd_adj;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [DIG_BITS-1:0]    dig_left_ff, dig_left_in;
   logic [1:0]             pos_ff, pos_in, pos_dec;
   len_type                printed_ff, printed_in;
   cap_type                cap_ff, cap_in;
   logic                   first_ff, first_in;
   logic                   sep_ff, sep_in;
   char_type               group_char_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   char_type               rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_status_ff, rsp_status_in;
   len_type                rsp_length_ff, rsp_length_in;
   logic [3:0]             top_digit;

   assign top_digit = bcd_ff[BCD_BITS-1 -: 4];

   // add-3 correction on every BCD digit before the shift
   always_comb begin
      for (int i = 0; i < NDIG; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   // digits-left mod 3 after dropping one digit
   always_comb begin
      case (pos_ff)
         2'd0:    pos_dec = 2'd2;
         2'd1:    pos_dec = 2'd0;
         2'd2:    pos_dec = 2'd1;
         default: pos_dec = 2'd0;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      bin_in        = bin_ff;
      bcd_in        = bcd_ff;
      cnt_in        = cnt_ff;
      dig_left_in   = dig_left_ff;
      pos_in        = pos_ff;
      printed_in    = printed_ff;
      cap_in        = cap_ff;
      first_in      = first_ff;
      sep_in        = sep_ff;
      rsp_valid_in  = 1'b0;
      rsp_char_in   = rsp_char_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      rsp_length_in = rsp_length_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               bin_in      = req_value[VALUE_WIDTH-1:0];
               bcd_in      = '0;
               cnt_in      = '0;
               dig_left_in = DIG_BITS'(NDIG);
               pos_in      = 2'(NDIG % 3);
               printed_in  = LEN_BITS'(PRINTED_MAX);
               cap_in      = req_capacity;
               first_in    = 1'b1;
               sep_in      = 1'b0;
               state_in    = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in = {bcd_adj[BCD_BITS-2:0], bin_ff[VALUE_WIDTH-1]};
            bin_in = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(VALUE_WIDTH - 1)) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (dig_left_ff > DIG_BITS'(1) && top_digit == 4'd0) begin
               bcd_in      = {bcd_ff[BCD_BITS-5:0], 4'd0};
               dig_left_in = dig_left_ff - 1'b1;
               pos_in      = pos_dec;
               // dropping a digit at a group boundary also drops a separator
               printed_in  = printed_ff - ((pos_ff == 2'd1) ? LEN_BITS'(2) : LEN_BITS'(1));
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (cap_ff <= CAP_BITS'(printed_ff)) begin
               rsp_valid_in  = 1'b1;
               rsp_char_in   = CHAR_NONE;
               rsp_last_in   = 1'b1;
               rsp_status_in = STATUS_OVERFLOW;
               rsp_length_in = '0;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_OK;
            if (pos_ff == 2'd0 && !first_ff && !sep_ff) begin
               rsp_char_in   = group_char_ff;
               rsp_last_in   = 1'b0;
               rsp_length_in = '0;
               sep_in        = 1'b1;
            end else begin
               rsp_char_in = ASCII_ZERO + CHAR_BITS'(top_digit);
               bcd_in      = {bcd_ff[BCD_BITS-5:0], 4'd0};
               dig_left_in = dig_left_ff - 1'b1;
               pos_in      = pos_dec;
               first_in    = 1'b0;
               sep_in      = 1'b0;
               if (dig_left_ff == DIG_BITS'(1)) begin
                  rsp_last_in   = 1'b1;
                  rsp_length_in = printed_ff;
                  state_in      = ST_IDLE;
               end else begin
                  rsp_last_in   = 1'b0;
                  rsp_length_in = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         group_char_ff <= GROUP_CHAR_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            group_char_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      bin_ff        <= bin_in;
      bcd_ff        <= bcd_in;
      cnt_ff        <= cnt_in;
      dig_left_ff   <= dig_left_in;
      pos_ff        <= pos_in;
      printed_ff    <= printed_in;
      cap_ff        <= cap_in;
      first_ff      <= first_in;
      sep_ff        <= sep_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_length_ff <= rsp_length_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_length   = rsp_length_ff;

endmodule

// ----- rtl/core/gdf_checker.sv -----
// ----------------------------------------------------------------------------
// gdf_checker
// Port-level checks on the grouped decimal formatter, bound to grouped_decimal_formatter_unit.
// ----------------------------------------------------------------------------
module gdf_checker
   import gdf_pkg::*;
(
   input logic     clock,
   input logic     reset,
   input logic     start,
   input logic     busy,
   input logic     rsp_valid,
   input char_type rsp_char_out,
   input logic     rsp_last,
   input logic     rsp_status,
   input len_type  rsp_length
);

   // an accepted request makes the unit busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("unit not busy after accepted request");

   // overflow is a single, empty, terminating beat
   a_overflow_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OVERFLOW |->
         rsp_last && rsp_char_out == CHAR_NONE && rsp_length == '0)
      else $error("malformed overflow beat");

   a_length_only_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_length == '0 && rsp_status == STATUS_OK)
      else $error("length or status on a non-final beat");

   a_ok_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last && rsp_status == STATUS_OK |-> rsp_length != '0)
      else $error("zero length on successful final beat");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("beat directly after final beat");

endmodule

bind grouped_decimal_formatter_unit gdf_checker u_gdf_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_char_out (rsp_char_out),
   .rsp_last     (rsp_last),
   .rsp_status   (rsp_status),
   .rsp_length   (rsp_length)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks grouped_decimal_formatter_unit: numbers go in on the start/busy
// handshake, the expected character beats are worked out at acceptance and
// compared in order against every rsp_valid strobe. The group character is
// changed between phases while the unit is idle.
// ----------------------------------------------------------------------------
module testbench;
   import gdf_pkg::*;

   localparam int TB_VALUE_WIDTH = 64;
   localparam logic [VALUE_BITS-1:0] VALUE_MASK =
      (TB_VALUE_WIDTH >= 64) ? '1 : ((64'd1 << TB_VALUE_WIDTH) - 64'd1);
   localparam int RUN_LIMIT   = 600000;
   localparam int TAIL_CYCLES = 150;

   typedef enum logic [1:0] {
      ENTRY_ITEM,
      ENTRY_CSR,
      ENTRY_DRAIN
   } entry_kind_t;

   typedef struct {
      entry_kind_t           kind;
      logic [VALUE_BITS-1:0] value;
      cap_type               capacity;
      char_type              sep;
      int unsigned           gap;
   } entry_t;

   typedef struct {
      char_type ch;
      logic     last;
      logic     status;
      len_type  length;
   } char_beat_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [VALUE_BITS-1:0] req_value = '0;
   cap_type               req_capacity = '0;
   logic                  rsp_valid;
   char_type              rsp_char_out;
   logic                  rsp_last;
   logic                  rsp_status;
   len_type               rsp_length;
   logic                  csr_we = 1'b0;
   char_type              csr_wdata = GROUP_CHAR_RESET;

   entry_t      pending_entries [$];
   char_beat_t  expected_chars [$];
   char_type    sep_model;
   int unsigned due_count = 0;
   int unsigned seen_count = 0;
   int unsigned mismatch_count = 0;
   int unsigned idle_cycles = 0;
   int unsigned cycle_count = 0;

   grouped_decimal_formatter_unit #(
      .VALUE_WIDTH(TB_VALUE_WIDTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_value   (req_value),
      .req_capacity(req_capacity),
      .rsp_valid   (rsp_valid),
      .rsp_char_out(rsp_char_out),
      .rsp_last    (rsp_last),
      .rsp_status  (rsp_status),
      .rsp_length  (rsp_length),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Expected beats for one number: leading group unpadded, later groups
   // padded to three digits behind the separator.
   function automatic void predict_grouped_text(input logic [VALUE_BITS-1:0] raw,
                                                input cap_type cap, input char_type sep);
      logic [VALUE_BITS-1:0] rest;
      int unsigned grp [7];
      int unsigned ngrp;
      int unsigned top;
      int unsigned lead;
      int unsigned printed;
      int unsigned v;
      char_type    text [$];
      rest = raw & VALUE_MASK;
      ngrp = 0;
      do begin
         grp[ngrp] = int'(rest % 64'd1000);
         rest = rest / 64'd1000;
         ngrp++;
      end while (rest != 0 && ngrp < 7);
      top = grp[ngrp-1];
      lead = 1 + (top > 9) + (top > 99);
      printed = lead + 4 * (ngrp - 1);
      if (cap < printed + 1) begin
         expected_chars.push_back('{CHAR_NONE, 1'b1, STATUS_OVERFLOW, '0});
         due_count++;
         return;
      end
      if (lead == 3)
         text.push_back(char_type'(ASCII_ZERO + top / 100));
      if (lead >= 2)
         text.push_back(char_type'(ASCII_ZERO + (top / 10) % 10));
      text.push_back(char_type'(ASCII_ZERO + top % 10));
      for (int g = ngrp - 1; g > 0; g--) begin
         v = grp[g-1];
         text.push_back(sep);
         text.push_back(char_type'(ASCII_ZERO + v / 100));
         text.push_back(char_type'(ASCII_ZERO + (v / 10) % 10));
         text.push_back(char_type'(ASCII_ZERO + v % 10));
      end
      foreach (text[i]) begin
         if (i == text.size() - 1)
            expected_chars.push_back('{text[i], 1'b1, STATUS_OK, len_type'(text.size())});
         else
            expected_chars.push_back('{text[i], 1'b0, STATUS_OK, '0});
      end
      due_count += text.size();
   endfunction

   // Driver: one NBA per signal per edge, decided through the drive_* vars.
   always @(posedge clock) begin : driver
      logic   drive_start;
      logic   drive_we;
      logic   drained;
      entry_t head;
      if (reset) begin
         start <= 1'b0;
         csr_we <= 1'b0;
         sep_model = GROUP_CHAR_RESET;
         idle_cycles = 0;
      end else begin
         drive_start = start;
         drive_we = 1'b0;
         if (csr_we)
            sep_model = csr_wdata;
         if (start && !busy) begin
            predict_grouped_text(req_value, req_capacity, sep_model);
            drive_start = 1'b0;
            idle_cycles = 0;
         end
         drained = (seen_count == due_count) && !busy;
         if (!drive_start && !csr_we && pending_entries.size() != 0) begin
            head = pending_entries[0];
            case (head.kind)
               ENTRY_ITEM: begin
                  // a nonzero gap counts idle cycles only
                  if (head.gap != 0 && (busy || idle_cycles < head.gap)) begin
                     if (!busy)
                        idle_cycles++;
                  end else begin
                     req_value <= head.value;
                     req_capacity <= head.capacity;
                     drive_start = 1'b1;
                     void'(pending_entries.pop_front());
                  end
               end
               ENTRY_CSR: begin
                  if (drained) begin
                     csr_wdata <= head.sep;
                     drive_we = 1'b1;
                     void'(pending_entries.pop_front());
                  end
               end
               default: begin
                  if (drained) begin
                     idle_cycles = 0;
                     void'(pending_entries.pop_front());
                  end
               end
            endcase
         end
         start <= drive_start;
         csr_we <= drive_we;
      end
   end

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      char_beat_t want;
      if (!reset && rsp_valid) begin
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual char %0d last %0b",
                     $time, rsp_char_out, rsp_last);
            mismatch_count++;
         end else begin
            want = expected_chars.pop_front();
            check_field("char_out", want.ch, rsp_char_out);
            check_field("last", want.last, rsp_last);
            check_field("status", want.status, rsp_status);
            check_field("length", want.length, rsp_length);
            seen_count <= seen_count + 1;
         end
      end
   end

   task automatic queue_item(input logic [VALUE_BITS-1:0] value, input cap_type cap,
                             input int unsigned gap);
      pending_entries.push_back('{ENTRY_ITEM, value, cap, '0, gap});
   endtask

   task automatic queue_csr(input char_type sep);
      pending_entries.push_back('{ENTRY_CSR, '0, '0, sep, 0});
   endtask

   task automatic queue_drain();
      pending_entries.push_back('{ENTRY_DRAIN, '0, '0, '0, 0});
   endtask

   function automatic logic [VALUE_BITS-1:0] random_value();
      logic [VALUE_BITS-1:0] p;
      p = 64'd1;
      if ($urandom_range(0, 7) == 0) begin
         // around a power of ten, where the group layout changes
         repeat ($urandom_range(0, 19)) p = p * 64'd10;
         return p - $urandom_range(0, 1);
      end
      return {$urandom, $urandom} >> $urandom_range(0, 63);
   endfunction

   function automatic cap_type random_capacity();
      case ($urandom_range(0, 3))
         0, 1:    return cap_type'($urandom_range(0, 30));
         2:       return 8'd255;
         default: return cap_type'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin : stimulus
      int unsigned gap;
      // directed: reset separator first
      queue_item(64'd0, 8'd255, 0);
      queue_item(64'd0, 8'd2, 3);
      queue_item(64'd0, 8'd1, 0);
      queue_item(64'd0, 8'd0, 1);
      queue_item(64'd9, 8'd255, 0);
      queue_item(64'd10, 8'd255, 5);
      queue_item(64'd99, 8'd255, 0);
      queue_item(64'd100, 8'd4, 0);
      queue_item(64'd999, 8'd3, 2);
      queue_item(64'd1000, 8'd6, 0);
      queue_item(64'd1000, 8'd5, 11);
      queue_item(64'd1001, 8'd255, 0);
      queue_item(64'd99999, 8'd255, 0);
      queue_item(64'd100000, 8'd255, 7);
      queue_item(64'd1000000, 8'd255, 0);
      queue_item(64'd12345678, 8'd255, 0);
      queue_item(64'd10000000000000000000, 8'd255, 0);
      queue_item(64'h8000_0000_0000_0000, 8'd255, 4);
      queue_item('1, 8'd27, 0);
      queue_item('1, 8'd26, 0);
      queue_drain();
      queue_csr(8'h00);
      queue_item('1, 8'd255, 0);
      queue_item(64'd1234, 8'd255, 9);
      queue_csr(8'hFF);
      queue_item(64'd987654321, 8'd255, 0);
      queue_item(64'hFFFF_FFFF_0000_0000, 8'd200, 0);

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0:       queue_csr(8'h2E);
            1:       queue_csr(8'h00);
            2:       queue_csr(8'hFF);
            7:       queue_csr(GROUP_CHAR_RESET);
            default: queue_csr(char_type'($urandom_range(0, 255)));
         endcase
         for (int n = 0; n < 44; n++) begin
            gap = (phase % 2 == 1) ? 0 : $urandom_range(0, 11);
            queue_item(random_value(), random_capacity(), gap);
            if ($urandom_range(0, 19) == 0)
               queue_drain();
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      while (pending_entries.size() != 0 || seen_count != due_count || busy || start)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (expected_chars.size() != 0) begin
         $display("%0t: %0d expected beats never arrived", $time, expected_chars.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : watchdog
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/gdf_pkg.sv
rtl/core/grouped_decimal_formatter_unit.sv
rtl/core/gdf_checker.sv
tb/testbench.sv
